>>> rtl/ldfl_pkg.sv
// Shared types and codes for the LED driver frame loader.
// Holds the command and output event encodings; no dependencies.
package ldfl_pkg;

    // Input command codes (tuser of the slave side); code 7 is unused
    typedef enum logic [2:0] {
        CMD_SET_GS     = 3'd0,
        CMD_SET_ALL_GS = 3'd1,
        CMD_SET_DC     = 3'd2,
        CMD_SET_ALL_DC = 3'd3,
        CMD_REQ_GS     = 3'd4,
        CMD_REQ_DC     = 3'd5,
        CMD_TICK       = 3'd6
    } cmd_t;

    // Output event codes (tuser of the master side)
    typedef enum logic [2:0] {
        EV_BLANK_HIGH   = 3'd0,
        EV_BLANK_LOW    = 3'd1,
        EV_LATCH        = 3'd2,
        EV_MODE_HIGH    = 3'd3,
        EV_MODE_LOW_CLK = 3'd4,
        EV_SHIFT        = 3'd5
    } ev_t;

    localparam int GS_BITS_PER_CH = 12;
    localparam int DC_BITS_PER_CH = 6;

endpackage

>>> rtl/led_driver_frame_loader.sv
// Frame loader for a constant-current LED driver: grayscale and dot-correction
// shift images in byte memories, command decode and serial event sequencer.
// Depends on ldfl_pkg.
//
//  channel  | dir | tdata (low bit first)                 | tuser     | tlast
//  ---------+-----+---------------------------------------+-----------+------------
//  s_axis   | in  | channel[4:0] level[16:5] load_dc_now[17]| command | -
//  m_axis   | out | data_byte[7:0]                        | event_res | last result
//
// A single-channel set reads, merges and writes each touched byte in turn (two
// for grayscale, one or two for dot correction); a set-all sweeps the image at
// one byte per cycle; a request that is not an immediate load only sets a flag
// for the next tick. A tick or an immediate load emits one result per cycle
// while the sink is ready; the image streams through the single read port of
// its memory at one byte per cycle while the sink is ready, each read issued
// ahead of its byte. Reset clears control state and the per-byte written flags
// at once, so unwritten image bytes read as zero and no clearing pass is needed.
// A stalled sink holds the output register and freezes the sequencer; a new
// item is taken as soon as the sequencer is idle, even while the last result
// of the previous item still waits in the output register.
module led_driver_frame_loader #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // channel[4:0], level[16:5], load_dc_now[17]
    input  logic [2:0]  s_axis_tuser,   // command[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // data_byte[7:0]
    output logic [2:0]  m_axis_tuser,   // event_res[2:0]
    output logic        m_axis_tlast    // last
);

    localparam int GS_BITS  = NUM_CHANNELS * ldfl_pkg::GS_BITS_PER_CH;
    localparam int DC_BITS  = NUM_CHANNELS * ldfl_pkg::DC_BITS_PER_CH;
    localparam int GS_BYTES = (GS_BITS + 7) / 8;
    localparam int DC_BYTES = (DC_BITS + 7) / 8;
    localparam int AW       = $clog2(GS_BYTES);
    localparam int DC_AW    = $clog2(DC_BYTES);
    localparam int GS_REM   = GS_BITS - 8 * (GS_BYTES - 1);
    localparam int DC_REM   = DC_BITS - 8 * (DC_BYTES - 1);
    localparam logic [7:0] GS_LAST_MASK = 8'hFF << (8 - GS_REM);
    localparam logic [7:0] DC_LAST_MASK = 8'hFF << (8 - DC_REM);
    localparam logic [AW-1:0] GS_LAST = AW'(GS_BYTES - 1);
    localparam logic [AW-1:0] DC_LAST = AW'(DC_BYTES - 1);
    localparam logic [5:0] NCH = 6'(NUM_CHANNELS);

    // Pending event queue bits, emitted lowest first
    localparam int Q_BLANK_HIGH = 0;
    localparam int Q_LATCH      = 1;
    localparam int Q_MODE_LOW   = 2;
    localparam int Q_BLANK_LOW  = 3;
    localparam int Q_MODE_HIGH  = 4;
    localparam int Q_SHIFT_ZERO = 5;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_RMW1   = 7'b0000010,
        ST_RMW2   = 7'b0000100,
        ST_FILL   = 7'b0001000,
        ST_EVT    = 7'b0010000,
        ST_STREAM = 7'b0100000,
        ST_POST   = 7'b1000000
    } state_t;

    // Input field unpacking
    logic [2:0]  in_cmd;
    logic [4:0]  in_ch;
    logic [11:0] in_level;
    logic        in_now;
    assign in_cmd   = s_axis_tuser;
    assign in_ch    = s_axis_tdata[4:0];
    assign in_level = s_axis_tdata[16:5];
    assign in_now   = s_axis_tdata[17];

    // Image memories with registered read
    logic [7:0] gs_mem [GS_BYTES];
    logic [7:0] dc_mem [DC_BYTES];
    logic [7:0] gs_q_reg, dc_q_reg;
    logic       gs_qv_reg, dc_qv_reg;
    logic [GS_BYTES-1:0] gs_vld_reg;
    logic [DC_BYTES-1:0] dc_vld_reg;

    logic          rd_en, rd_dc, wr_en, wr_dc;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [7:0]    wr_data;
    logic          gs_we, gs_re, dc_we, dc_re;

    assign gs_we = wr_en & ~wr_dc;
    assign dc_we = wr_en &  wr_dc;
    assign gs_re = rd_en & ~rd_dc;
    assign dc_re = rd_en &  rd_dc;

    always_ff @(posedge clk)
    begin
        if (gs_we)
        begin
            gs_mem[wr_addr] <= wr_data;
        end
        if (gs_re)
        begin
            gs_q_reg <= gs_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dc_we)
        begin
            dc_mem[wr_addr[DC_AW-1:0]] <= wr_data;
        end
        if (dc_re)
        begin
            dc_q_reg <= dc_mem[rd_addr[DC_AW-1:0]];
        end
    end

    // Written flags: an unwritten byte reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_vld_reg <= '0;
            dc_vld_reg <= '0;
            gs_qv_reg  <= 1'b0;
            dc_qv_reg  <= 1'b0;
        end
        else
        begin
            if (gs_we)
            begin
                gs_vld_reg[wr_addr] <= 1'b1;
            end
            if (dc_we)
            begin
                dc_vld_reg[wr_addr[DC_AW-1:0]] <= 1'b1;
            end
            if (gs_re)
            begin
                gs_qv_reg <= gs_vld_reg[rd_addr];
            end
            if (dc_re)
            begin
                dc_qv_reg <= dc_vld_reg[rd_addr[DC_AW-1:0]];
            end
        end
    end

    // Control and sequencer state
    state_t        state_reg, state_next;
    logic          sel_dc_reg, sel_dc_next;
    logic          two_reg, two_next;
    logic [AW-1:0] a0_reg, a0_next, a1_reg, a1_next;
    logic [7:0]    d0_reg, d0_next, m0_reg, m0_next;
    logic [7:0]    d1_reg, d1_next, m1_reg, m1_next;
    logic [11:0]   lvl_reg, lvl_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [1:0]    ph_reg, ph_next;
    logic [5:0]    evq_reg, evq_next;
    logic          strm_reg, strm_next;
    logic          post_reg, post_next;
    logic          md_reg, md_next;
    logic          lp_reg, lp_next;
    logic          gr_reg, gr_next;
    logic          cr_reg, cr_next;
    logic          out_valid_reg, out_valid_next;
    ldfl_pkg::ev_t out_event_reg, out_event_next;
    logic [7:0]    out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_event_reg;
    assign m_axis_tlast  = out_last_reg;

    // Slot of a channel in the reversed image, and its byte offsets
    logic          ch_ok;
    logic [4:0]    slot;
    logic [6:0]    slot3;
    logic [AW-1:0] gs_a0, dc_a0;
    logic [5:0]    dcv;

    assign ch_ok = ({1'b0, in_ch} < NCH);
    assign slot  = 5'(NCH - 6'd1 - {1'b0, in_ch});
    assign slot3 = {2'b00, slot} + {1'b0, slot, 1'b0};
    assign gs_a0 = AW'(slot3 >> 1);
    assign dc_a0 = AW'(slot3 >> 2);
    assign dcv   = in_level[5:0];

    logic          accept, can_load, last_byte;
    logic [7:0]    rd_byte, merge0, merge1, fill_byte, fill_mask;
    logic [AW-1:0] last_idx;
    logic [2:0]    pick;
    logic [5:0]    evq_rest;

    assign accept    = s_axis_tvalid & s_axis_tready;
    assign can_load  = ~out_valid_reg | m_axis_tready;
    assign rd_byte   = sel_dc_reg ? (dc_qv_reg ? dc_q_reg : 8'h00)
                                  : (gs_qv_reg ? gs_q_reg : 8'h00);
    assign merge0    = (rd_byte & ~m0_reg) | (d0_reg & m0_reg);
    assign merge1    = (rd_byte & ~m1_reg) | (d1_reg & m1_reg);
    assign last_idx  = sel_dc_reg ? DC_LAST : GS_LAST;
    assign last_byte = (idx_reg == last_idx);
    assign fill_mask = last_byte ? (sel_dc_reg ? DC_LAST_MASK : GS_LAST_MASK) : 8'hFF;

    // Repeating three-byte pattern of a set-all sweep
    always_comb
    begin
        fill_byte = 8'h00;
        if (sel_dc_reg)
        begin
            case (ph_reg)
                2'd0:    fill_byte = {lvl_reg[5:0], lvl_reg[5:4]};
                2'd1:    fill_byte = {lvl_reg[3:0], lvl_reg[5:2]};
                default: fill_byte = {lvl_reg[1:0], lvl_reg[5:0]};
            endcase
        end
        else
        begin
            case (ph_reg)
                2'd0:    fill_byte = lvl_reg[11:4];
                2'd1:    fill_byte = {lvl_reg[3:0], lvl_reg[11:8]};
                default: fill_byte = lvl_reg[7:0];
            endcase
        end
    end

    // Lowest pending event
    always_comb
    begin
        pick = 3'd0;
        for (int i = 5; i >= 0; i--)
        begin
            if (evq_reg[i])
            begin
                pick = 3'(i);
            end
        end
        evq_rest = evq_reg & ~(6'd1 << pick);
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_dc_next    = sel_dc_reg;
        two_next       = two_reg;
        a0_next        = a0_reg;
        a1_next        = a1_reg;
        d0_next        = d0_reg;
        m0_next        = m0_reg;
        d1_next        = d1_reg;
        m1_next        = m1_reg;
        lvl_next       = lvl_reg;
        idx_next       = idx_reg;
        ph_next        = ph_reg;
        evq_next       = evq_reg;
        strm_next      = strm_reg;
        post_next      = post_reg;
        md_next        = md_reg;
        lp_next        = lp_reg;
        gr_next        = gr_reg;
        cr_next        = cr_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_event_next = out_event_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        rd_en          = 1'b0;
        rd_dc          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_dc          = sel_dc_reg;
        wr_addr        = a0_reg;
        wr_data        = merge0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_cmd)
                        ldfl_pkg::CMD_SET_GS:
                        begin
                            if (ch_ok)
                            begin
                                // Two bytes: one whole, one sharing a nibble
                                sel_dc_next = 1'b0;
                                two_next    = 1'b1;
                                a0_next     = gs_a0;
                                a1_next     = gs_a0 + AW'(1);
                                if (slot[0])
                                begin
                                    d0_next = {4'h0, in_level[11:8]};
                                    m0_next = 8'h0F;
                                    d1_next = in_level[7:0];
                                    m1_next = 8'hFF;
                                end
                                else
                                begin
                                    d0_next = in_level[11:4];
                                    m0_next = 8'hFF;
                                    d1_next = {in_level[3:0], 4'h0};
                                    m1_next = 8'hF0;
                                end
                                rd_en      = 1'b1;
                                rd_dc      = 1'b0;
                                rd_addr    = gs_a0;
                                state_next = ST_RMW1;
                            end
                        end
                        ldfl_pkg::CMD_SET_DC:
                        begin
                            if (ch_ok)
                            begin
                                sel_dc_next = 1'b1;
                                a0_next     = dc_a0;
                                a1_next     = dc_a0 + AW'(1);
                                d1_next     = 8'h00;
                                m1_next     = 8'h00;
                                two_next    = 1'b0;
                                case (slot[1:0])
                                    2'd0:
                                    begin
                                        d0_next = {dcv, 2'b00};
                                        m0_next = 8'hFC;
                                    end
                                    2'd1:
                                    begin
                                        d0_next  = {6'h00, dcv[5:4]};
                                        m0_next  = 8'h03;
                                        d1_next  = {dcv[3:0], 4'h0};
                                        m1_next  = 8'hF0;
                                        two_next = 1'b1;
                                    end
                                    2'd2:
                                    begin
                                        d0_next  = {4'h0, dcv[5:2]};
                                        m0_next  = 8'h0F;
                                        d1_next  = {dcv[1:0], 6'h00};
                                        m1_next  = 8'hC0;
                                        two_next = 1'b1;
                                    end
                                    default:
                                    begin
                                        d0_next = {2'b00, dcv};
                                        m0_next = 8'h3F;
                                    end
                                endcase
                                rd_en      = 1'b1;
                                rd_dc      = 1'b1;
                                rd_addr    = dc_a0;
                                state_next = ST_RMW1;
                            end
                        end
                        ldfl_pkg::CMD_SET_ALL_GS:
                        begin
                            sel_dc_next = 1'b0;
                            lvl_next    = in_level;
                            idx_next    = '0;
                            ph_next     = 2'd0;
                            state_next  = ST_FILL;
                        end
                        ldfl_pkg::CMD_SET_ALL_DC:
                        begin
                            sel_dc_next = 1'b1;
                            lvl_next    = in_level;
                            idx_next    = '0;
                            ph_next     = 2'd0;
                            state_next  = ST_FILL;
                        end
                        ldfl_pkg::CMD_REQ_GS:
                        begin
                            gr_next = 1'b1;
                        end
                        ldfl_pkg::CMD_REQ_DC:
                        begin
                            if (in_now)
                            begin
                                // Immediate load: mode high, dummy byte, image, latch
                                md_next     = 1'b1;
                                evq_next    = 6'b110000;
                                strm_next   = 1'b1;
                                post_next   = 1'b1;
                                sel_dc_next = 1'b1;
                                idx_next    = '0;
                                rd_en       = 1'b1;
                                rd_dc       = 1'b1;
                                rd_addr     = '0;
                                state_next  = ST_EVT;
                            end
                            else
                            begin
                                cr_next = 1'b1;
                            end
                        end
                        ldfl_pkg::CMD_TICK:
                        begin
                            evq_next               = '0;
                            evq_next[Q_BLANK_HIGH] = 1'b1;
                            evq_next[Q_LATCH]      = lp_reg;
                            evq_next[Q_MODE_LOW]   = md_reg;
                            evq_next[Q_BLANK_LOW]  = 1'b1;
                            evq_next[Q_MODE_HIGH]  = cr_reg;
                            evq_next[Q_SHIFT_ZERO] = cr_reg;
                            strm_next   = cr_reg | gr_reg;
                            post_next   = 1'b0;
                            sel_dc_next = cr_reg;
                            idx_next    = '0;
                            rd_en       = cr_reg | gr_reg;
                            rd_dc       = cr_reg;
                            rd_addr     = '0;
                            lp_next     = cr_reg | gr_reg;
                            md_next     = cr_reg;
                            cr_next     = 1'b0;
                            gr_next     = cr_reg & gr_reg;
                            state_next  = ST_EVT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RMW1:
            begin
                wr_en   = 1'b1;
                wr_addr = a0_reg;
                wr_data = merge0;
                if (two_reg)
                begin
                    rd_en      = 1'b1;
                    rd_dc      = sel_dc_reg;
                    rd_addr    = a1_reg;
                    state_next = ST_RMW2;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RMW2:
            begin
                wr_en      = 1'b1;
                wr_addr    = a1_reg;
                wr_data    = merge1;
                state_next = ST_IDLE;
            end
            ST_FILL:
            begin
                // Padding bits of the last byte stay zero
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = fill_byte & fill_mask;
                idx_next = idx_reg + AW'(1);
                ph_next  = (ph_reg == 2'd2) ? 2'd0 : ph_reg + 2'd1;
                if (last_byte)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EVT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = 8'h00;
                    out_last_next  = (evq_rest == '0) & ~strm_reg;
                    case (pick)
                        3'(Q_BLANK_HIGH): out_event_next = ldfl_pkg::EV_BLANK_HIGH;
                        3'(Q_LATCH):      out_event_next = ldfl_pkg::EV_LATCH;
                        3'(Q_MODE_LOW):   out_event_next = ldfl_pkg::EV_MODE_LOW_CLK;
                        3'(Q_BLANK_LOW):  out_event_next = ldfl_pkg::EV_BLANK_LOW;
                        3'(Q_MODE_HIGH):  out_event_next = ldfl_pkg::EV_MODE_HIGH;
                        default:          out_event_next = ldfl_pkg::EV_SHIFT;
                    endcase
                    evq_next = evq_rest;
                    if (evq_rest == '0)
                    begin
                        state_next = strm_reg ? ST_STREAM : ST_IDLE;
                    end
                end
            end
            ST_STREAM:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_event_next = ldfl_pkg::EV_SHIFT;
                    out_data_next  = rd_byte;
                    out_last_next  = last_byte & ~post_reg;
                    if (last_byte)
                    begin
                        state_next = post_reg ? ST_POST : ST_IDLE;
                    end
                    else
                    begin
                        // Fetch the next byte while this one goes out
                        idx_next = idx_reg + AW'(1);
                        rd_en    = 1'b1;
                        rd_dc    = sel_dc_reg;
                        rd_addr  = idx_reg + AW'(1);
                    end
                end
            end
            ST_POST:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_event_next = ldfl_pkg::EV_LATCH;
                    out_data_next  = 8'h00;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            evq_reg       <= '0;
            strm_reg      <= 1'b0;
            post_reg      <= 1'b0;
            md_reg        <= 1'b0;
            lp_reg        <= 1'b0;
            gr_reg        <= 1'b0;
            cr_reg        <= 1'b0;
            sel_dc_reg    <= 1'b0;
            two_reg       <= 1'b0;
            idx_reg       <= '0;
            ph_reg        <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            evq_reg       <= evq_next;
            strm_reg      <= strm_next;
            post_reg      <= post_next;
            md_reg        <= md_next;
            lp_reg        <= lp_next;
            gr_reg        <= gr_next;
            cr_reg        <= cr_next;
            sel_dc_reg    <= sel_dc_next;
            two_reg       <= two_next;
            idx_reg       <= idx_next;
            ph_reg        <= ph_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        a0_reg        <= a0_next;
        a1_reg        <= a1_next;
        d0_reg        <= d0_next;
        m0_reg        <= m0_next;
        d1_reg        <= d1_next;
        m1_reg        <= m1_next;
        lvl_reg       <= lvl_next;
        out_event_reg <= out_event_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

endmodule

>>> rtl/ldfl_checker.sv
// Port-level checker for the LED driver frame loader, bound to the top level.
// Depends on ldfl_pkg and led_driver_frame_loader.
module ldfl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Hold a result until it is taken
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Control events carry a zero data byte
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ldfl_pkg::EV_SHIFT) |-> (m_axis_tdata == 8'h00))
        else $error("nonzero data on a control event");

    // Blank high opens a tick and is never its final result
    a_blank_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ldfl_pkg::EV_BLANK_HIGH) |-> !m_axis_tlast)
        else $error("blank high marked as last");

endmodule

bind led_driver_frame_loader ldfl_checker u_ldfl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
